// ----- rtl/precharge_power_switch_sequencer_core_macros.svh -----
// Assertion macros for the precharge sequencer checker.
// Included by files that assert; needs nothing else.
`ifndef PRECHARGE_POWER_SWITCH_SEQUENCER_CORE_MACROS_SVH
`define PRECHARGE_POWER_SWITCH_SEQUENCER_CORE_MACROS_SVH

// same-cycle implication
`define PPSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PPSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ppss_pkg.sv -----
// Shared types and constants of the precharge power switch sequencer.
// No dependencies.
`timescale 1ns / 1ps

package ppss_pkg;

   localparam int CFG_WIDTH       = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int LOCK_WIDTH      = 8;
   localparam int PHASE_WIDTH     = 2;
   localparam int ELAPSED_WIDTH   = 17;
   localparam int BLINK_WIDTH     = 17;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRECHARGE_MS  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STATUS_PERIOD = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLINK_HALF    = 2'd2;

   localparam logic [CFG_WIDTH-1:0] PRECHARGE_MS_RESET  = 16'd100;
   localparam logic [CFG_WIDTH-1:0] STATUS_PERIOD_RESET = 16'd100;
   localparam logic [CFG_WIDTH-1:0] BLINK_HALF_RESET    = 16'd20;

   localparam logic [PHASE_WIDTH-1:0] PHASE_OFF       = 2'd0;
   localparam logic [PHASE_WIDTH-1:0] PHASE_PRECHARGE = 2'd1;
   localparam logic [PHASE_WIDTH-1:0] PHASE_ON        = 2'd2;

   localparam logic [ELAPSED_WIDTH-1:0] ELAPSED_MAX = 17'h1FFFF;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] precharge_ms;
      logic [CFG_WIDTH-1:0] status_period_ms;
      logic [CFG_WIDTH-1:0] blink_half_period_ms;
   } cfg_type;

   typedef struct packed {
      logic                   main_switch_on;
      logic                   precharge_switch_on;
      logic                   indicator_level;
      logic [PHASE_WIDTH-1:0] power_phase;
      logic                   status_send;
      logic                   status_switch;
      logic [LOCK_WIDTH-1:0]  status_lock;
   } result_type;

endpackage

// ----- rtl/ppss_csr.sv -----
// Configuration registers of the precharge sequencer.
// Depends on ppss_pkg.
`timescale 1ns / 1ps

module ppss_csr import ppss_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PRECHARGE_MS:  cfg_in.precharge_ms         = csr_data;
            CSR_STATUS_PERIOD: cfg_in.status_period_ms     = csr_data;
            CSR_BLINK_HALF:    cfg_in.blink_half_period_ms = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.precharge_ms         <= PRECHARGE_MS_RESET;
         cfg_ff.status_period_ms     <= STATUS_PERIOD_RESET;
         cfg_ff.blink_half_period_ms <= BLINK_HALF_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/ppss_step.sv -----
// Sequencer state and the per-tick update: phase, timers, counters, outputs.
// Depends on ppss_pkg.
`timescale 1ns / 1ps

module ppss_step import ppss_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  cfg_type               cfg,
   input  logic                  switch_on,
   input  logic                  command_valid,
   input  logic [LOCK_WIDTH-1:0] command_lock,
   output result_type            result
);

   logic [PHASE_WIDTH-1:0]   phase_ff, phase_in;
   logic [ELAPSED_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic [LOCK_WIDTH-1:0]    lock_ff, lock_in;
   logic [CFG_WIDTH-1:0]     status_cnt_ff, status_cnt_in;
   logic [BLINK_WIDTH-1:0]   blink_ff, blink_in;
   logic                     last_sw_ff, last_sw_in;

   logic [CFG_WIDTH-1:0]     status_next;
   logic                     due;
   logic [CFG_WIDTH-1:0]     half;
   logic [BLINK_WIDTH-1:0]   full;
   logic [BLINK_WIDTH-1:0]   blink_cur;
   logic [BLINK_WIDTH-1:0]   blink_inc;
   logic [ELAPSED_WIDTH-1:0] elapsed_inc;

   always_comb begin
      status_next   = status_cnt_ff + 1'b1;
      due           = (status_next >= cfg.status_period_ms);
      status_cnt_in = due ? '0 : status_next;

      lock_in = lock_ff;
      if (due && (lock_ff != '0)) begin
         lock_in = lock_ff - 1'b1;
      end
      if (command_valid && (command_lock != '0)) begin
         lock_in = command_lock;
      end

      half      = (cfg.blink_half_period_ms == '0) ? CFG_WIDTH'(1) : cfg.blink_half_period_ms;
      full      = {half, 1'b0};
      blink_cur = (blink_ff >= full) ? '0 : blink_ff;
      blink_inc = blink_cur + 1'b1;
      blink_in  = (blink_inc >= full) ? '0 : blink_inc;

      result.power_phase         = phase_ff;
      result.status_send         = due;
      result.status_switch       = due & last_sw_ff;
      result.status_lock         = due ? lock_ff : '0;
      result.main_switch_on      = 1'b0;
      result.precharge_switch_on = 1'b0;
      result.indicator_level     = 1'b1;
      unique case (phase_ff)
         PHASE_PRECHARGE: begin
            result.precharge_switch_on = 1'b1;
            result.indicator_level     = (blink_cur >= {1'b0, half});
         end
         PHASE_ON: begin
            result.main_switch_on      = 1'b1;
            result.precharge_switch_on = 1'b1;
            result.indicator_level     = 1'b0;
         end
         default: begin
            result.indicator_level     = 1'b1;
         end
      endcase

      last_sw_in = switch_on;

      elapsed_inc = elapsed_ff;
      if ((phase_ff == PHASE_PRECHARGE) && (elapsed_ff != ELAPSED_MAX)) begin
         elapsed_inc = elapsed_ff + 1'b1;
      end
      elapsed_in = elapsed_inc;
      phase_in   = phase_ff;
      if (switch_on) begin
         if (phase_ff == PHASE_PRECHARGE) begin
            if (elapsed_inc > {1'b0, cfg.precharge_ms}) begin
               phase_in = PHASE_ON;
            end
         end else if (phase_ff != PHASE_ON) begin
            elapsed_in = '0;
            phase_in   = PHASE_PRECHARGE;
         end
      end else if (lock_in == '0) begin
         phase_in = PHASE_OFF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_OFF;
         elapsed_ff    <= '0;
         lock_ff       <= '0;
         status_cnt_ff <= '0;
         blink_ff      <= '0;
         last_sw_ff    <= 1'b0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         elapsed_ff    <= elapsed_in;
         lock_ff       <= lock_in;
         status_cnt_ff <= status_cnt_in;
         blink_ff      <= blink_in;
         last_sw_ff    <= last_sw_in;
      end
   end

endmodule

// ----- rtl/precharge_power_switch_sequencer_core.sv -----
// Path from req accept to the earliest rsp accept: input register, then result register.
// Throughput: one word per cycle while the result is not stalled.
// A stalled result holds the input register; one more word is taken only while it is empty.
// Reset: synchronous, active high; clears state, valid flags and restores
// register defaults (precharge 100, status period 100, blink half period 20).
`timescale 1ns / 1ps

module precharge_power_switch_sequencer_core import ppss_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_switch_on,
   input  logic                       req_command_valid,
   input  logic [LOCK_WIDTH-1:0]      req_command_lock,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_main_switch_on,
   output logic                       rsp_precharge_switch_on,
   output logic                       rsp_indicator_level,
   output logic [PHASE_WIDTH-1:0]     rsp_power_phase,
   output logic                       rsp_status_send,
   output logic                       rsp_status_switch,
   output logic [LOCK_WIDTH-1:0]      rsp_status_lock
);

   cfg_type    cfg;
   result_type result;
   result_type rsp_ff;

   logic                  in_valid_ff, in_valid_in;
   logic                  in_switch_ff;
   logic                  in_cmd_valid_ff;
   logic [LOCK_WIDTH-1:0] in_cmd_lock_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  out_ready;
   logic                  advance;
   logic                  req_fire;

   ppss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ppss_step u_step (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .cfg           (cfg),
      .switch_on     (in_switch_ff),
      .command_valid (in_cmd_valid_ff),
      .command_lock  (in_cmd_lock_ff),
      .result        (result)
   );

   assign out_ready = ~rsp_valid_ff | rsp_ready;
   assign advance   = in_valid_ff & out_ready;
   assign req_ready = ~in_valid_ff | out_ready;
   assign req_fire  = req_valid & req_ready;

   always_comb begin
      in_valid_in  = req_fire | (in_valid_ff & ~out_ready);
      rsp_valid_in = advance | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_switch_ff    <= req_switch_on;
         in_cmd_valid_ff <= req_command_valid;
         in_cmd_lock_ff  <= req_command_lock;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_main_switch_on      = rsp_ff.main_switch_on;
   assign rsp_precharge_switch_on = rsp_ff.precharge_switch_on;
   assign rsp_indicator_level     = rsp_ff.indicator_level;
   assign rsp_power_phase         = rsp_ff.power_phase;
   assign rsp_status_send         = rsp_ff.status_send;
   assign rsp_status_switch       = rsp_ff.status_switch;
   assign rsp_status_lock         = rsp_ff.status_lock;

endmodule

// ----- rtl/ppss_checker.sv -----
// Port-level checks of the precharge sequencer, bound to the top level.
// Depends on ppss_pkg and precharge_power_switch_sequencer_core_macros.svh.
`timescale 1ns / 1ps
`include "precharge_power_switch_sequencer_core_macros.svh"

module ppss_checker import ppss_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       csr_valid,
   input logic                       csr_ready,
   input logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input logic [CFG_WIDTH-1:0]       csr_data,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       req_switch_on,
   input logic                       req_command_valid,
   input logic [LOCK_WIDTH-1:0]      req_command_lock,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_main_switch_on,
   input logic                       rsp_precharge_switch_on,
   input logic                       rsp_indicator_level,
   input logic [PHASE_WIDTH-1:0]     rsp_power_phase,
   input logic                       rsp_status_send,
   input logic                       rsp_status_switch,
   input logic [LOCK_WIDTH-1:0]      rsp_status_lock
);

   `PPSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_power_phase) && $stable(rsp_status_lock), "rsp word changed while stalled")
   `PPSS_ASSERT_NOW(a_main_needs_pre, clock, reset, rsp_valid && rsp_main_switch_on, rsp_precharge_switch_on && !rsp_indicator_level && (rsp_power_phase == PHASE_ON), "main switch closed outside on phase")
   `PPSS_ASSERT_NOW(a_off_dark, clock, reset, rsp_valid && (rsp_power_phase == PHASE_OFF), !rsp_main_switch_on && !rsp_precharge_switch_on && rsp_indicator_level, "switch driven while off")
   `PPSS_ASSERT_NOW(a_no_report, clock, reset, rsp_valid && !rsp_status_send, !rsp_status_switch && (rsp_status_lock == '0), "status fields set without report")

endmodule

bind precharge_power_switch_sequencer_core ppss_checker u_ppss_checker (.*);
